### sv/stv_pkg.sv
// Shared types and constants for the sliding time-window charge sum.
// Used by stv_engine and sliding_time_window_sum_core; no dependencies.
package stv_pkg;

    localparam int TIME_W   = 64;
    localparam int CHARGE_W = 32;
    localparam int SUM_W    = 38;
    localparam int CNT_W    = 7;

    localparam logic [TIME_W-1:0] WINDOW_RESET = 64'd1000;

    typedef struct packed {
        logic [TIME_W-1:0]   hit_time;
        logic [CHARGE_W-1:0] hit_charge;
    } stv_hit_t;

    typedef struct packed {
        logic [TIME_W-1:0] window_start;
        logic [SUM_W-1:0]  window_charge;
        logic [CNT_W-1:0]  hit_count;
        logic [CNT_W-1:0]  evicted_count;
        logic              overflow;
    } stv_result_t;

endpackage

### sv/stv_queue.sv
// Two-entry register queue used on the input and result sides.
// Generic over payload width; no package dependency.
module stv_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] data_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

### sv/stv_engine.sv
// Back end: hit FIFO memory, eviction loop and running charge sum.
// Depends on stv_pkg for the hit and result types.
module stv_engine #(
    parameter int FIFO_DEPTH = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [stv_pkg::TIME_W-1:0] win_len,
    input  logic                      item_valid,
    input  stv_pkg::stv_hit_t         item,
    output logic                      item_take,
    input  logic                      res_ready,
    output logic                      res_valid,
    output stv_pkg::stv_result_t      res
);

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int SW = AW + 1;

    stv_pkg::stv_hit_t mem [FIFO_DEPTH];
    stv_pkg::stv_hit_t rd_reg;

    logic [AW-1:0]               head_reg, head_next;
    logic [CW-1:0]               occ_reg, occ_next;
    logic [stv_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [stv_pkg::CNT_W-1:0]   ev_reg, ev_next;
    logic                        ovf_reg, ovf_next;

    logic [stv_pkg::TIME_W-1:0]  lag;
    logic                        stale, go, evict_time, evict_force, evict, append;
    logic [SW-1:0]               tail_sum;
    logic [AW-1:0]               tail, head_inc;

    always_comb
    begin
        lag         = item.hit_time - rd_reg.hit_time;
        stale       = (occ_reg != '0) && (lag >= win_len);
        go          = item_valid && res_ready;
        evict_time  = go && !ovf_reg && stale;
        evict_force = go && !ovf_reg && !stale && (occ_reg == CW'(FIFO_DEPTH));
        evict       = evict_time || evict_force;
        append      = go && !evict;

        head_inc = (head_reg == AW'(FIFO_DEPTH - 1)) ? '0 : head_reg + AW'(1);
        tail_sum = SW'(head_reg) + SW'(occ_reg);
        if (tail_sum >= SW'(FIFO_DEPTH))
        begin
            tail_sum = tail_sum - SW'(FIFO_DEPTH);
        end
        tail = (occ_reg == '0) ? '0 : tail_sum[AW-1:0];

        head_next = head_reg;
        occ_next  = occ_reg;
        sum_next  = sum_reg;
        ev_next   = ev_reg;
        ovf_next  = ovf_reg;
        res       = '0;

        if (evict)
        begin
            head_next = head_inc;
            occ_next  = occ_reg - CW'(1);
            sum_next  = sum_reg - stv_pkg::SUM_W'(rd_reg.hit_charge);
            ev_next   = ev_reg + stv_pkg::CNT_W'(1);
            ovf_next  = evict_force;
        end
        else if (append)
        begin
            occ_next = occ_reg + CW'(1);
            ev_next  = '0;
            ovf_next = 1'b0;
            if (occ_reg == '0)
            begin
                head_next        = '0;
                sum_next         = stv_pkg::SUM_W'(item.hit_charge);
                res.window_start = item.hit_time;
            end
            else
            begin
                sum_next         = sum_reg + stv_pkg::SUM_W'(item.hit_charge);
                res.window_start = rd_reg.hit_time;
            end
        end

        res.window_charge = sum_next;
        res.hit_count     = stv_pkg::CNT_W'(occ_next);
        res.evicted_count = ev_reg;
        res.overflow      = ovf_reg;
        res_valid         = append;
        item_take         = append;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            occ_reg  <= '0;
            sum_reg  <= '0;
            ev_reg   <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            occ_reg  <= occ_next;
            sum_reg  <= sum_next;
            ev_reg   <= ev_next;
            ovf_reg  <= ovf_next;
        end
    end

    // Read port always tracks the next head; write-first when the append lands on it.
    always_ff @(posedge clk)
    begin
        if (append)
        begin
            mem[tail] <= item;
        end
        if (append && (tail == head_next))
        begin
            rd_reg <= item;
        end
        else
        begin
            rd_reg <= mem[head_next];
        end
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(FIFO_DEPTH))
        else $error("occupancy above FIFO depth");

    a_ovf_occ: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (occ_reg == CW'(FIFO_DEPTH - 1)))
        else $error("forced eviction left wrong occupancy");

    a_append_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        append |=> (occ_reg != '0))
        else $error("window empty after append");

    a_evict_dec: assert property (@(posedge clk) disable iff (!rst_n)
        evict |=> (occ_reg == $past(occ_reg) - CW'(1)))
        else $error("eviction did not reduce occupancy");

    a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
        append |-> (res.hit_count != '0 || FIFO_DEPTH > 126))
        else $error("result with zero hit count");

endmodule

### sv/sliding_time_window_sum_core.sv
// Sliding time-window charge sum: input queue, eviction engine, result queue.
// Depends on stv_pkg, stv_queue and stv_engine.
//
// Usage:
//   Hits enter through a queue-style port: hit_time/hit_charge are taken on a
//   clock edge with push high and full low. Each hit yields exactly one result,
//   read queue-style: while empty is low the oldest result is on window_start,
//   window_charge, hit_count, evicted_count and overflow; pop with empty low
//   takes it.
//   The window length is written through cfg_valid/cfg_ready/cfg_data;
//   cfg_ready is always high. Write it only while no hit is in flight.
// Operation:
//   With nothing to evict, a hit passes from the input queue register through
//   the engine into the result queue register. The engine evicts stale hits one
//   at a time before it appends a hit; when the hit FIFO is full and no hit is
//   stale, one hit is forced out first and overflow is flagged. Each hit is
//   evicted once. The single read port of the hit memory sets the rate of one
//   eviction per cycle while the result queue is not full.
// Reset and stalls:
//   rst_n clears the window (empty, sum zero) and sets the window length to 1000.
//   Two-entry queues sit on both sides; when results are not popped the
//   result queue fills, the engine stops and full rises on the input side.
module sliding_time_window_sum_core #(
    parameter int FIFO_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [stv_pkg::TIME_W-1:0]    hit_time,
    input  logic [stv_pkg::CHARGE_W-1:0]  hit_charge,
    output logic                          empty,
    input  logic                          pop,
    output logic [stv_pkg::TIME_W-1:0]    window_start,
    output logic [stv_pkg::SUM_W-1:0]     window_charge,
    output logic [stv_pkg::CNT_W-1:0]     hit_count,
    output logic [stv_pkg::CNT_W-1:0]     evicted_count,
    output logic                          overflow,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [stv_pkg::TIME_W-1:0]    cfg_data
);

    logic [stv_pkg::TIME_W-1:0] wlen_reg;

    stv_pkg::stv_hit_t    in_hit, eng_hit;
    stv_pkg::stv_result_t eng_res, out_res;
    logic                 in_empty, eng_take, out_full, eng_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= stv_pkg::WINDOW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            wlen_reg <= cfg_data;
        end
    end

    assign in_hit.hit_time   = hit_time;
    assign in_hit.hit_charge = hit_charge;

    stv_queue #(
        .WIDTH($bits(stv_pkg::stv_hit_t))
    ) u_in_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .din   (in_hit),
        .pop   (eng_take),
        .empty (in_empty),
        .dout  (eng_hit)
    );

    stv_engine #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .win_len       (wlen_reg),
        .item_valid    (!in_empty),
        .item          (eng_hit),
        .item_take     (eng_take),
        .res_ready     (!out_full),
        .res_valid     (eng_valid),
        .res           (eng_res)
    );

    stv_queue #(
        .WIDTH($bits(stv_pkg::stv_result_t))
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (eng_valid),
        .full  (out_full),
        .din   (eng_res),
        .pop   (pop),
        .empty (empty),
        .dout  (out_res)
    );

    assign window_start  = out_res.window_start;
    assign window_charge = out_res.window_charge;
    assign hit_count     = out_res.hit_count;
    assign evicted_count = out_res.evicted_count;
    assign overflow      = out_res.overflow;

endmodule

### verif/testbench.sv
// Self-checking testbench for sliding_time_window_sum_core.
// Drives hits through the queue-style input, checks each window result against
// a local model of the hit FIFO and charge sum. Depends on stv_pkg and the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_PROBES    = 17;
    localparam int N_PHASES    = 7;
    localparam int PEND_DEPTH  = 16;

    typedef struct {
        logic [stv_pkg::TIME_W-1:0]   t;
        logic [stv_pkg::CHARGE_W-1:0] q;
        bit                           fixed;
        stv_pkg::stv_result_t         want;
    } probe_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         push = 1'b0;
    logic                         full;
    logic [stv_pkg::TIME_W-1:0]   hit_time = '0;
    logic [stv_pkg::CHARGE_W-1:0] hit_charge = '0;
    logic                         empty;
    logic                         pop = 1'b0;
    logic [stv_pkg::TIME_W-1:0]   window_start;
    logic [stv_pkg::SUM_W-1:0]    window_charge;
    logic [stv_pkg::CNT_W-1:0]    hit_count;
    logic [stv_pkg::CNT_W-1:0]    evicted_count;
    logic                         overflow;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [stv_pkg::TIME_W-1:0]   cfg_data = '0;

    // local copy of the window state
    logic [stv_pkg::TIME_W-1:0]   held_time [DEPTH];
    logic [stv_pkg::CHARGE_W-1:0] held_charge [DEPTH];
    int unsigned                  oldest = 0;
    int unsigned                  held = 0;
    logic [stv_pkg::SUM_W-1:0]    charge_sum = '0;
    logic [stv_pkg::TIME_W-1:0]   window_origin = '0;
    logic [stv_pkg::TIME_W-1:0]   window_len = stv_pkg::WINDOW_RESET;

    // expected results in order, as a ring with running write/read counts
    stv_pkg::stv_result_t         pending_windows [PEND_DEPTH];
    int                           pend_wr = 0;
    int                           pend_rd = 0;
    probe_row_t                   probes [N_PROBES];
    int                           failures = 0;
    int                           cycle_count = 0;
    int                           burst_left = 0;
    logic [stv_pkg::TIME_W-1:0]   last_time = '0;
    bit                           hold_req = 1'b0;
    int                           hold_left = 0;
    int                           mode_left = 0;
    int                           stall_mode = 0;

    sliding_time_window_sum_core #(
        .FIFO_DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .hit_time(hit_time),
        .hit_charge(hit_charge),
        .empty(empty),
        .pop(pop),
        .window_start(window_start),
        .window_charge(window_charge),
        .hit_count(hit_count),
        .evicted_count(evicted_count),
        .overflow(overflow),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Evict on age, then force one out if still full, then append the hit.
    function automatic stv_pkg::stv_result_t slide_window(
        input logic [stv_pkg::TIME_W-1:0] t,
        input logic [stv_pkg::CHARGE_W-1:0] q);
        stv_pkg::stv_result_t       r;
        logic [stv_pkg::TIME_W-1:0] lag;
        int unsigned                dropped;
        int unsigned                tail;
        r = '0;
        dropped = 0;
        while (held != 0) begin
            lag = t - held_time[oldest];
            if (lag < window_len) begin
                if (held < DEPTH)
                    break;
                r.overflow = 1'b1;
            end
            charge_sum = charge_sum - held_charge[oldest];
            oldest = (oldest + 1) % DEPTH;
            held--;
            dropped++;
            if (r.overflow)
                break;
        end
        if (held == 0) begin
            oldest = 0;
            window_origin = t;
            charge_sum = stv_pkg::SUM_W'(q);
        end
        else begin
            window_origin = held_time[oldest];
            charge_sum = charge_sum + q;
        end
        tail = (oldest + held) % DEPTH;
        held_time[tail] = t;
        held_charge[tail] = q;
        held++;
        r.window_start = window_origin;
        r.window_charge = charge_sum;
        r.hit_count = stv_pkg::CNT_W'(held);
        r.evicted_count = stv_pkg::CNT_W'(dropped);
        return r;
    endfunction

    function automatic probe_row_t probe(input logic [stv_pkg::TIME_W-1:0] t,
                                         input logic [stv_pkg::CHARGE_W-1:0] q,
                                         input bit fixed,
                                         input logic [stv_pkg::TIME_W-1:0] start,
                                         input logic [stv_pkg::SUM_W-1:0] sum,
                                         input int count,
                                         input int dropped);
        probe_row_t row;
        row.t = t;
        row.q = q;
        row.fixed = fixed;
        row.want.window_start = start;
        row.want.window_charge = sum;
        row.want.hit_count = stv_pkg::CNT_W'(count);
        row.want.evicted_count = stv_pkg::CNT_W'(dropped);
        row.want.overflow = 1'b0;
        return row;
    endfunction

    task automatic send_hit(input logic [stv_pkg::TIME_W-1:0] t,
                            input logic [stv_pkg::CHARGE_W-1:0] q,
                            input bit fixed, input stv_pkg::stv_result_t want);
        stv_pkg::stv_result_t predicted;
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        push <= 1'b1;
        hit_time <= t;
        hit_charge <= q;
        @(posedge clk);
        while (full) @(posedge clk);
        predicted = slide_window(t, q);
        pending_windows[pend_wr % PEND_DEPTH] = fixed ? want : predicted;
        pend_wr++;
        burst_left--;
        last_time = t;
    endtask

    // Only written with the block idle: every hit yields a result, so an empty
    // expectation ring means the engine is done.
    task automatic load_window(input logic [stv_pkg::TIME_W-1:0] len);
        push <= 1'b0;
        while (pend_wr != pend_rd) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= len;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        window_len = len;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    // result side: own stall pattern plus one long hold-off on request
    always @(posedge clk) begin
        stv_pkg::stv_result_t want;
        if (rst_n) begin
            if (pop && !empty) begin
                if (pend_wr == pend_rd) begin
                    $error("result popped with no item outstanding");
                    failures++;
                end
                else begin
                    want = pending_windows[pend_rd % PEND_DEPTH];
                    pend_rd++;
                    check_field("window_start", want.window_start, window_start);
                    check_field("window_charge", 64'(want.window_charge),
                                64'(window_charge));
                    check_field("hit_count", 64'(want.hit_count), 64'(hit_count));
                    check_field("evicted_count", 64'(want.evicted_count),
                                64'(evicted_count));
                    check_field("overflow", 64'(want.overflow), 64'(overflow));
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left != 0) begin
                hold_left--;
                pop <= 1'b0;
            end
            else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 160);
                end
                else
                    mode_left--;
                case (stall_mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    default: pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [stv_pkg::TIME_W-1:0]   t;
        logic [stv_pkg::TIME_W-1:0]   span;
        logic [stv_pkg::TIME_W-1:0]   anchor;
        logic [stv_pkg::CHARGE_W-1:0] q;
        logic [stv_pkg::TIME_W-1:0]   phase_len [N_PHASES];
        int                           phase_items [N_PHASES];
        int                           pick;

        // window length 1000 out of reset
        probes[0]  = probe(64'd0, 32'd0, 1'b1, 64'd0, 38'd0, 1, 0);
        probes[1]  = probe(64'd999, '1, 1'b1, 64'd0, 38'hFFFF_FFFF, 2, 0);
        // lag of exactly the window length is evicted
        probes[2]  = probe(64'd1999, 32'd5, 1'b1, 64'd1999, 38'd5, 1, 2);
        // time running backwards wraps to a huge lag
        probes[3]  = probe(64'd100, 32'd7, 1'b1, 64'd100, 38'd7, 1, 1);
        probes[4]  = probe('1, '1, 1'b1, '1, 38'hFFFF_FFFF, 1, 1);
        // wrap from all-ones to zero is a lag of one
        probes[5]  = probe(64'd0, '1, 1'b1, '1, 38'h1_FFFF_FFFE, 2, 0);
        probes[6]  = probe(64'd500, 32'd1, 1'b0, '0, '0, 0, 0);
        probes[7]  = probe(64'd1500, 32'd2, 1'b1, 64'd1500, 38'd2, 1, 3);
        probes[8]  = probe(64'd1500, 32'd3, 1'b0, '0, '0, 0, 0);
        probes[9]  = probe(64'd2499, 32'd4, 1'b0, '0, '0, 0, 0);
        probes[10] = probe(64'd2500, 32'd6, 1'b0, '0, '0, 0, 0);
        probes[11] = probe(64'h8000_0000_0000_0000, 32'h8000_0000, 1'b1,
                           64'h8000_0000_0000_0000, 38'h8000_0000, 1, 2);
        probes[12] = probe(64'h5555_5555_5555_5555, 32'h5555_5555, 1'b0, '0, '0, 0, 0);
        probes[13] = probe(64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 1'b0, '0, '0, 0, 0);
        probes[14] = probe(64'hAAAA_AAAA_AAAA_AAAB, 32'h1234_5678, 1'b0, '0, '0, 0, 0);
        probes[15] = probe(64'hAAAA_AAAA_AAAA_AAAA + 64'd999, '1, 1'b0, '0, '0, 0, 0);
        probes[16] = probe(64'hAAAA_AAAA_AAAA_AAAA + 64'd1000, 32'd1, 1'b0,
                           '0, '0, 0, 0);

        // zero length evicts everything; all-ones keeps the FIFO full
        phase_len[0] = 64'd1;
        phase_len[1] = 64'd0;
        phase_len[2] = '1;
        phase_len[3] = {$urandom, $urandom};
        phase_len[4] = 64'($urandom_range(1, 4096));
        phase_len[5] = stv_pkg::WINDOW_RESET;
        phase_len[6] = 64'($urandom_range(1, 100));
        phase_items = '{120, 40, 150, 150, 200, 150, 150};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_PROBES; i++)
            send_hit(probes[i].t, probes[i].q, probes[i].fixed, probes[i].want);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            load_window(phase_len[ph]);
            for (int n = 0; n < phase_items[ph]; n++) begin
                if (ph == 4 && n == 50)
                    hold_req = 1'b1;
                pick = $urandom_range(0, 99);
                span = window_len >> $urandom_range(2, 7);
                anchor = (held != 0) ? held_time[oldest] : last_time;
                if (pick < 6)
                    t = {$urandom, $urandom};
                else if (pick < 10)
                    t = last_time - $urandom_range(1, 5000);
                else if (pick < 18)
                    // land right at the age limit of the oldest hit
                    t = anchor + window_len - 64'd1 + $urandom_range(0, 2);
                else if (span == 0)
                    t = last_time + $urandom_range(0, 1);
                else
                    t = last_time + ({$urandom, $urandom} % (span + 64'd1));
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    q = '0;
                else if (pick == 1)
                    q = '1;
                else
                    q = $urandom;
                send_hit(t, q, 1'b0, '0);
            end
        end

        push <= 1'b0;
        while (pend_wr != pend_rd) @(posedge clk);
        repeat (20) @(posedge clk);
        if (failures == 0 && pend_wr == pend_rd)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
